// ----- sv/assert_macros.svh -----
// Assertion helpers for the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define RPQ_ASSERT_HOLDS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define RPQ_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- sv/rpq_pkg.sv -----
`default_nettype none

package rpq_pkg;

    // Fixed widths of the transaction fields.
    localparam int ID_W         = 5;
    localparam int PRIO_FIELD_W = 8;
    localparam int COUNT_W      = 6;

    // Command codes.
    localparam logic CMD_REMOVE = 1'b0;
    localparam logic CMD_ADD    = 1'b1;

    typedef struct packed {
        logic                    command;
        logic [ID_W-1:0]         process_id;
        logic [PRIO_FIELD_W-1:0] priority_req;
    } item_t;

    typedef struct packed {
        logic                    served_valid;
        logic [ID_W-1:0]         served_id;
        logic [PRIO_FIELD_W-1:0] served_priority;
        logic                    add_accepted;
        logic [COUNT_W-1:0]      queue_count;
        logic                    queue_empty;
    } result_t;

    // Broadcast to every cell of the row in the cycle a transaction is taken.
    typedef struct packed {
        logic insert;
        logic remove;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- sv/rpq_cell.sv -----
`default_nettype none

module rpq_cell #(
    parameter int PRIO_BITS = 8
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  rpq_pkg::cell_ctrl_t         ctrl,
    input  wire  [rpq_pkg::ID_W-1:0]    new_id,
    input  wire  [PRIO_BITS-1:0]        new_prio,
    input  wire                         left_valid,
    input  wire  [rpq_pkg::ID_W-1:0]    left_id,
    input  wire  [PRIO_BITS-1:0]        left_prio,
    input  wire                         left_stays,
    input  wire                         right_valid,
    input  wire  [rpq_pkg::ID_W-1:0]    right_id,
    input  wire  [PRIO_BITS-1:0]        right_prio,
    output logic                        valid,
    output logic [rpq_pkg::ID_W-1:0]    id,
    output logic [PRIO_BITS-1:0]        prio,
    output logic                        stays
);
    import rpq_pkg::*;

    logic                 valid_reg;
    logic                 valid_next;
    logic [ID_W-1:0]      id_reg;
    logic [ID_W-1:0]      id_next;
    logic [PRIO_BITS-1:0] prio_reg;
    logic [PRIO_BITS-1:0] prio_next;

    // An entry keeps its slot on an insert only if it outranks the new one,
    // so equal priorities let the newer entry go ahead.
    assign stays = valid_reg && (prio_reg > new_prio);

    always_comb
    begin
        valid_next = valid_reg;
        id_next    = id_reg;
        prio_next  = prio_reg;
        if (ctrl.insert && !stays)
        begin
            if (left_stays)
            begin
                valid_next = 1'b1;
                id_next    = new_id;
                prio_next  = new_prio;
            end
            else
            begin
                valid_next = left_valid;
                id_next    = left_id;
                prio_next  = left_prio;
            end
        end
        else if (ctrl.remove)
        begin
            valid_next = right_valid;
            id_next    = right_id;
            prio_next  = right_prio;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        prio_reg <= prio_next;
    end

    assign valid = valid_reg;
    assign id    = id_reg;
    assign prio  = prio_reg;

endmodule

`default_nettype wire

// ----- sv/rpq_skid.sv -----
`default_nettype none

module rpq_skid (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               load_valid,
    output logic              load_ready,
    input  rpq_pkg::result_t  load,
    output logic              result_valid,
    input  wire               result_ready,
    output rpq_pkg::result_t  result
);
    import rpq_pkg::*;

    logic    main_valid_reg;
    logic    main_valid_next;
    result_t main_reg;
    result_t main_next;
    logic    spare_valid_reg;
    logic    spare_valid_next;
    result_t spare_reg;
    result_t spare_next;
    logic    out_fire;

    // The spare entry catches one result while the output is stalled.
    assign load_ready = !spare_valid_reg;
    assign out_fire   = main_valid_reg && result_ready;

    always_comb
    begin
        main_valid_next  = main_valid_reg;
        main_next        = main_reg;
        spare_valid_next = spare_valid_reg;
        spare_next       = spare_reg;
        if (spare_valid_reg)
        begin
            if (out_fire)
            begin
                main_next        = spare_reg;
                spare_valid_next = 1'b0;
            end
        end
        else if (load_valid)
        begin
            if (!main_valid_reg || out_fire)
            begin
                main_valid_next = 1'b1;
                main_next       = load;
            end
            else
            begin
                spare_valid_next = 1'b1;
                spare_next       = load;
            end
        end
        else if (out_fire)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg  <= 1'b0;
            spare_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg  <= main_valid_next;
            spare_valid_reg <= spare_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg  <= main_next;
        spare_reg <= spare_next;
    end

    assign result_valid = main_valid_reg;
    assign result       = main_reg;

endmodule

`default_nettype wire

// ----- sv/process_ready_priority_queue_top.sv -----
// Ready queue of process identifiers, served in descending priority order.
// Input channel item/item_valid/item_ready carries one command transaction:
// an add (process_id with priority_req) or a remove of the head entry.
// Output channel result/result_valid/result_ready returns exactly one result
// transaction per command: the served entry on a remove, the accept flag on
// an add, and the entry count and empty flag as they stand afterwards.
// The result of an accepted command is registered before it is presented.
// Throughput is one command per cycle while item_ready is high: the row of
// cells compares against the new priority in parallel and shifts at once, so
// the row update sets the rate. An add of a process that is already queued,
// or an id at or above NUM_PROCS, is rejected without changing the queue.
// Reset clears every slot valid bit, every ready mark and the count, so the
// queue comes up empty and accepts commands as soon as reset is released.
// When the receiver stalls, one result waits at the output and one more is
// held in a spare register; item_ready drops only once both are occupied.
`default_nettype none
`include "assert_macros.svh"

module process_ready_priority_queue_top #(
    parameter int NUM_PROCS = 32,
    parameter int PRIO_BITS = 8
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               item_valid,
    output logic              item_ready,
    input  rpq_pkg::item_t    item,
    output logic              result_valid,
    input  wire               result_ready,
    output rpq_pkg::result_t  result
);
    import rpq_pkg::*;

    // Process ids are only ID_W bits wide, so no more marks than ids exist.
    localparam int NUM_MARKS = (NUM_PROCS < (1 << ID_W)) ? NUM_PROCS : (1 << ID_W);
    localparam int CNT_W     = $clog2(NUM_PROCS + 1);

    logic                 accept;
    logic                 is_add;
    logic                 is_remove;
    logic                 id_ok;
    logic                 already_ready;
    logic                 full;
    logic                 do_insert;
    logic                 do_serve;
    logic [PRIO_BITS-1:0] prio_in;
    cell_ctrl_t           ctrl;

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [NUM_MARKS-1:0] marks_reg;
    logic [NUM_MARKS-1:0] marks_next;

    // Contents of the cell row; cell 0 is the head of the queue.
    logic [NUM_PROCS-1:0] cell_valid;
    logic [NUM_PROCS-1:0] cell_stays;
    logic [ID_W-1:0]      cell_id   [NUM_PROCS];
    logic [PRIO_BITS-1:0] cell_prio [NUM_PROCS];

    result_t              result_next;
    logic                 load_ready;

    assign item_ready = load_ready;
    assign accept     = item_valid && item_ready;
    assign is_add     = accept && (item.command == CMD_ADD);
    assign is_remove  = accept && (item.command == CMD_REMOVE);
    assign prio_in    = PRIO_BITS'(item.priority_req);
    assign id_ok      = 32'(item.process_id) < NUM_PROCS;
    assign full       = count_reg == CNT_W'(NUM_PROCS);

    // Look up the ready mark of the process being added.
    always_comb
    begin
        already_ready = 1'b0;
        for (int i = 0; i < NUM_MARKS; i++)
        begin
            if (marks_reg[i] && (item.process_id == ID_W'(i)))
            begin
                already_ready = 1'b1;
            end
        end
    end

    assign do_insert   = is_add && id_ok && !already_ready && !full;
    assign do_serve    = is_remove && cell_valid[0];
    assign ctrl.insert = do_insert;
    assign ctrl.remove = do_serve;

    // The count and the marks follow the queue contents: an insert sets the
    // added process's mark, a serve clears the mark of the head entry.
    always_comb
    begin
        count_next = count_reg;
        marks_next = marks_reg;
        if (do_insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_serve)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        for (int i = 0; i < NUM_MARKS; i++)
        begin
            if (do_insert && (item.process_id == ID_W'(i)))
            begin
                marks_next[i] = 1'b1;
            end
            if (do_serve && (cell_id[0] == ID_W'(i)))
            begin
                marks_next[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            marks_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            marks_reg <= marks_next;
        end
    end

    // The row of cells. On an insert every cell decides in parallel whether
    // it keeps its entry, takes the new one or takes its left neighbor's; on
    // a serve every cell takes its right neighbor's entry.
    for (genvar g = 0; g < NUM_PROCS; g++)
    begin : g_cell
        logic                 left_valid;
        logic [ID_W-1:0]      left_id;
        logic [PRIO_BITS-1:0] left_prio;
        logic                 left_stays;
        logic                 right_valid;
        logic [ID_W-1:0]      right_id;
        logic [PRIO_BITS-1:0] right_prio;

        if (g == 0)
        begin : g_head
            // The head has nothing ahead of it, so a new entry that
            // outranks or ties it lands here.
            assign left_valid = 1'b0;
            assign left_id    = '0;
            assign left_prio  = '0;
            assign left_stays = 1'b1;
        end
        else
        begin : g_body
            assign left_valid = cell_valid[g-1];
            assign left_id    = cell_id[g-1];
            assign left_prio  = cell_prio[g-1];
            assign left_stays = cell_stays[g-1];
        end

        if (g == NUM_PROCS - 1)
        begin : g_tail
            assign right_valid = 1'b0;
            assign right_id    = '0;
            assign right_prio  = '0;
        end
        else
        begin : g_inner
            assign right_valid = cell_valid[g+1];
            assign right_id    = cell_id[g+1];
            assign right_prio  = cell_prio[g+1];
        end

        rpq_cell #(
            .PRIO_BITS (PRIO_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .new_id      (item.process_id),
            .new_prio    (prio_in),
            .left_valid  (left_valid),
            .left_id     (left_id),
            .left_prio   (left_prio),
            .left_stays  (left_stays),
            .right_valid (right_valid),
            .right_id    (right_id),
            .right_prio  (right_prio),
            .valid       (cell_valid[g]),
            .id          (cell_id[g]),
            .prio        (cell_prio[g]),
            .stays       (cell_stays[g])
        );
    end

    // The result reports the head as it stood before the serve, and the
    // count as it stands after this transaction.
    always_comb
    begin
        result_next.served_valid    = do_serve;
        result_next.served_id       = do_serve ? cell_id[0] : '0;
        result_next.served_priority = do_serve ? PRIO_FIELD_W'(cell_prio[0]) : '0;
        result_next.add_accepted    = do_insert;
        result_next.queue_count     = COUNT_W'(count_next);
        result_next.queue_empty     = count_next == '0;
    end

    rpq_skid u_skid (
        .clk          (clk),
        .rst_n        (rst_n),
        .load_valid   (accept),
        .load_ready   (load_ready),
        .load         (result_next),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    `RPQ_ASSERT_HOLDS(a_count_matches_cells, clk, rst_n, $countones(cell_valid) == int'(count_reg), "entry count disagrees with occupied cells")
    `RPQ_ASSERT_HOLDS(a_marks_match_count, clk, rst_n, $countones(marks_reg) == int'(count_reg), "ready marks disagree with entry count")
    `RPQ_ASSERT_HOLDS(a_cells_packed, clk, rst_n, (cell_valid & (cell_valid + NUM_PROCS'(1))) == '0, "occupied cells are not packed toward the head")
    `RPQ_ASSERT_IMPLIES(a_stall_holds_result, clk, rst_n, !item_ready, result_valid, "input stalled with no result waiting")

endmodule

`default_nettype wire
